// ----- src/arm32_pc_relative_relocator_top_assert.svh -----
// Assertion macros shared by the relocator checker.
`ifndef ARM32_PC_RELATIVE_RELOCATOR_TOP_ASSERT_SVH
`define ARM32_PC_RELATIVE_RELOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/apr_pkg.sv -----
// Types and constants shared by the instruction relocator modules.
package apr_pkg;

    localparam int WORD_W    = 32;
    localparam int MAX_WORDS = 6;
    localparam int IDX_W     = 3;

    localparam logic [WORD_W-1:0] WINDOW_BYTES = 32'd8;

    localparam logic [WORD_W-1:0] OP_LDR_PC_LIT  = 32'hE51FF004;
    localparam logic [WORD_W-1:0] OP_ADD_LR_PC4  = 32'hE28FE004;
    localparam logic [WORD_W-1:0] OP_PUSH_R      = 32'hE52D0004;
    localparam logic [WORD_W-1:0] OP_LDR_R_PC8   = 32'hE59F0008;
    localparam logic [WORD_W-1:0] OP_POP_R       = 32'hE49D0004;
    localparam logic [WORD_W-1:0] OP_ADD_PC_PC0  = 32'hE28FF000;
    localparam logic [WORD_W-1:0] OP_LDR_RD_PC   = 32'hE51F0000;
    localparam logic [WORD_W-1:0] MASK_RN_CLEAR  = 32'hFFF0FFFF;

    localparam logic [WORD_W-1:0] REDIRECT_BL_OFS = 32'd12;
    localparam logic [WORD_W-1:0] REDIRECT_B_OFS  = 32'd8;

    typedef enum logic [1:0] {
        CFG_HOOK_ADDRESS      = 2'd0,
        CFG_NEW_ENTRY_ADDRESS = 2'd1,
        CFG_FIRST_FIX_LENGTH  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        CLS_BLX,
        CLS_BL,
        CLS_BCOND,
        CLS_B,
        CLS_BX_PC,
        CLS_ADD_PC,
        CLS_ADR_ADD,
        CLS_ADR_SUB,
        CLS_LDR_LIT,
        CLS_MOV_PC,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        logic [MAX_WORDS-1:0][WORD_W-1:0] words;
        logic [IDX_W-1:0]                 last_idx;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- src/arm32_pc_relative_relocator_top.sv -----
// Top level of the ARM32 PC-relative instruction relocator.
//
//  channel   signals                                      beat taken when
//  input     start, busy, instruction, pc_value,          start high, busy low
//            literal_word
//  config    cfg_write, cfg_index, cfg_data               cfg_write high
//  result    result_valid, out_word, is_last              result_valid high
//
// Each instruction yields 1 to 6 result beats, one per cycle, sent back to back until its
// last word. With nothing ahead of it, an instruction passes through the front-end input
// registers, a queue entry and the back-end output word register to reach the result port.
// The front end classifies and builds the whole sequence combinationally from its input registers
// and the back end serialises it, so intake rate is set by the single output word per cycle.
// Reset clears the queue, the control flags and the configuration registers to zero.
// The receiver cannot stall; busy rises only while the queue is full and a built item waits.
module arm32_pc_relative_relocator_top
    import apr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] instruction,
    input  logic [WORD_W-1:0] pc_value,
    input  logic [WORD_W-1:0] literal_word,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    output logic              result_valid,
    output logic [WORD_W-1:0] out_word,
    output logic              is_last
);

    q_status_t q_status;
    logic      push;
    desc_t     push_data;
    logic      pop;
    desc_t     head;

    apr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .instruction  (instruction),
        .pc_value     (pc_value),
        .literal_word (literal_word),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    apr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    apr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .out_word     (out_word),
        .is_last      (is_last)
    );

endmodule

// ----- src/apr_front.sv -----
// Front end: takes instructions, classifies them and builds the replacement sequence.
module apr_front
    import apr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] instruction,
    input  logic [WORD_W-1:0] pc_value,
    input  logic [WORD_W-1:0] literal_word,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    input  q_status_t         q_status,
    output logic              push,
    output desc_t             push_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] ins_reg;
    logic [WORD_W-1:0] pc_reg;
    logic [WORD_W-1:0] lit_reg;
    logic [WORD_W-1:0] hook_reg;
    logic [WORD_W-1:0] entry_reg;
    logic [4:0]        fix_reg;
    logic              accept;

    cls_t              cls;
    logic [WORD_W-1:0] br_off;
    logic [WORD_W-1:0] addend;
    logic              carry_in;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] diff;
    logic              in_win;
    logic [WORD_W-1:0] entry_bl;
    logic [WORD_W-1:0] entry_b;
    logic [WORD_W-1:0] entry_fix;
    logic [WORD_W-1:0] bcond_target;
    logic [3:0]        rd;
    logic [3:0]        rm;
    logic [3:0]        rr;
    logic [WORD_W-1:0] imm_ext;

    assign accept     = start && !busy;
    assign busy       = valid_reg && q_status.full;
    assign push       = valid_reg && !q_status.full;
    assign valid_next = accept ? 1'b1 : (push ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hook_reg  <= '0;
            entry_reg <= '0;
            fix_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HOOK_ADDRESS:      hook_reg  <= cfg_data;
                    CFG_NEW_ENTRY_ADDRESS: entry_reg <= cfg_data;
                    CFG_FIRST_FIX_LENGTH:  fix_reg   <= cfg_data[4:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_reg <= instruction;
            pc_reg  <= pc_value;
            lit_reg <= literal_word;
        end
    end

    always_comb
    begin
        if (ins_reg[31:25] == 7'b1111101)
            cls = CLS_BLX;
        else if (ins_reg[27:24] == 4'hB)
            cls = CLS_BL;
        else if (ins_reg[27:25] == 3'b101 && ins_reg[31:28] <= 4'hD)
            cls = CLS_BCOND;
        else if (ins_reg[31:25] == 7'b1110101)
            cls = CLS_B;
        else if ((ins_reg & 32'h0FF000FF) == 32'h0120001F)
            cls = CLS_BX_PC;
        else if ((ins_reg & 32'h0FEF0010) == 32'h008F0000)
            cls = CLS_ADD_PC;
        else if ((ins_reg & 32'h0FFF0000) == 32'h028F0000)
            cls = CLS_ADR_ADD;
        else if ((ins_reg & 32'h0FFF0000) == 32'h024F0000)
            cls = CLS_ADR_SUB;
        else if ((ins_reg & 32'h0E5F0000) == 32'h041F0000)
            cls = CLS_LDR_LIT;
        else if ((ins_reg & 32'h0FE00FFF) == 32'h01A0000F)
            cls = CLS_MOV_PC;
        else
            cls = CLS_OTHER;
    end

    // One adder serves both branch targets and the ADR forms.
    assign br_off  = {{6{ins_reg[23]}}, ins_reg[23:0], 2'b00};
    assign imm_ext = {20'd0, ins_reg[11:0]};

    always_comb
    begin
        addend   = '0;
        carry_in = 1'b0;
        case (cls)
            CLS_BLX:
            begin
                addend   = br_off | {30'd0, ins_reg[24], 1'b0};
                carry_in = 1'b1;
            end
            CLS_BL, CLS_BCOND, CLS_B: addend = br_off;
            CLS_ADR_ADD:              addend = imm_ext;
            CLS_ADR_SUB:
            begin
                addend   = ~imm_ext;
                carry_in = 1'b1;
            end
            default: addend = '0;
        endcase
    end

    assign target    = pc_reg + addend + {{(WORD_W-1){1'b0}}, carry_in};
    assign diff      = target - hook_reg;
    assign in_win    = diff < WINDOW_BYTES;
    assign entry_bl  = entry_reg + REDIRECT_BL_OFS;
    assign entry_b   = entry_reg + REDIRECT_B_OFS;
    assign entry_fix = entry_reg + {27'd0, fix_reg};

    always_comb
    begin
        bcond_target = target;
        if (in_win && diff[WORD_W-1:2] == '0)
            bcond_target = entry_reg;
        else if (in_win && diff[WORD_W-1:2] == 30'd1)
            bcond_target = entry_fix;
    end

    // Scratch register for the ADD form: highest of R12 downwards not used by Rd or Rm.
    assign rd = ins_reg[15:12];
    assign rm = ins_reg[3:0];

    always_comb
    begin
        if (rd != 4'd12 && rm != 4'd12)
            rr = 4'd12;
        else if (rd != 4'd11 && rm != 4'd11)
            rr = 4'd11;
        else
            rr = 4'd10;
    end

    always_comb
    begin
        push_data          = '0;
        push_data.last_idx = 3'd2;
        case (cls)
            CLS_BLX:
            begin
                push_data.words[0] = OP_ADD_LR_PC4;
                push_data.words[1] = OP_LDR_PC_LIT;
                push_data.words[2] = target;
            end
            CLS_BL:
            begin
                push_data.words[0] = OP_ADD_LR_PC4;
                push_data.words[1] = OP_LDR_PC_LIT;
                push_data.words[2] = in_win ? entry_bl : target;
            end
            CLS_BCOND:
            begin
                push_data.words[0] = {ins_reg[31:29], ~ins_reg[28], ins_reg[27:25], 24'd0, 1'b1};
                push_data.words[1] = OP_LDR_PC_LIT;
                push_data.words[2] = bcond_target;
            end
            CLS_B, CLS_BX_PC:
            begin
                push_data.last_idx = 3'd1;
                push_data.words[0] = OP_LDR_PC_LIT;
                push_data.words[1] = in_win ? entry_b : (cls == CLS_B ? target : pc_reg);
            end
            CLS_ADD_PC:
            begin
                push_data.last_idx = 3'd5;
                push_data.words[0] = OP_PUSH_R | {16'd0, rr, 12'd0};
                push_data.words[1] = OP_LDR_R_PC8 | {16'd0, rr, 12'd0};
                push_data.words[2] = (ins_reg & MASK_RN_CLEAR) | {12'd0, rr, 16'd0};
                push_data.words[3] = OP_POP_R | {16'd0, rr, 12'd0};
                push_data.words[4] = OP_ADD_PC_PC0;
                push_data.words[5] = pc_reg;
            end
            CLS_ADR_ADD, CLS_ADR_SUB, CLS_LDR_LIT, CLS_MOV_PC:
            begin
                push_data.words[0] = OP_LDR_RD_PC | {16'd0, ins_reg[15:12], 12'd0};
                push_data.words[1] = OP_ADD_PC_PC0;
                push_data.words[2] = (cls == CLS_LDR_LIT) ? lit_reg :
                                     (cls == CLS_MOV_PC) ? pc_reg : target;
            end
            default:
            begin
                push_data.last_idx = 3'd0;
                push_data.words[0] = ins_reg;
            end
        endcase
    end

endmodule

// ----- src/apr_queue.sv -----
// Short queue of built sequences between the front and back ends.
module apr_queue
    import apr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  desc_t     push_data,
    input  logic      pop,
    output desc_t     head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign status.full  = cnt_reg == CNT_W'(DEPTH);
    assign status.empty = cnt_reg == '0;
    assign head         = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- src/apr_back.sv -----
// Back end: sends the queued sequence one word per cycle.
module apr_back
    import apr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  desc_t             head,
    input  q_status_t         q_status,
    output logic              pop,
    output logic              result_valid,
    output logic [WORD_W-1:0] out_word,
    output logic              is_last
);

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              valid_reg;
    logic              last_reg;
    logic [WORD_W-1:0] word_reg;
    logic              at_last;

    assign at_last  = idx_reg == head.last_idx;
    assign pop      = !q_status.empty && at_last;
    assign idx_next = q_status.empty ? idx_reg : (at_last ? '0 : idx_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= !q_status.empty;
            last_reg  <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= head.words[idx_reg];
    end

    assign result_valid = valid_reg;
    assign out_word     = word_reg;
    assign is_last      = last_reg;

endmodule

// ----- src/apr_checker.sv -----
// Port-level checker for the relocator, bound to the top level.
`include "arm32_pc_relative_relocator_top_assert.svh"

module apr_checker
    import apr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [WORD_W-1:0] instruction,
    input logic [WORD_W-1:0] pc_value,
    input logic [WORD_W-1:0] literal_word,
    input logic              cfg_write,
    input logic [1:0]        cfg_index,
    input logic [WORD_W-1:0] cfg_data,
    input logic              result_valid,
    input logic [WORD_W-1:0] out_word,
    input logic              is_last
);

    // A sequence leaves without gaps until its last word.
    `APR_ASSERT_NEXT(a_seq_contiguous, clk, rst_n,
        result_valid && !is_last, result_valid, "gap inside a sequence")

    // The last-word mark never appears without a result beat.
    `APR_ASSERT_NOW(a_last_needs_valid, clk, rst_n,
        !result_valid, !is_last, "is_last without result_valid")

    // busy can only come up after an input beat was offered.
    `APR_ASSERT_NOW(a_busy_after_start, clk, rst_n,
        $rose(busy), $past(start), "busy rose with no start")

    // A beat taken with nothing in flight reaches the result port through the front, queue and back-end registers.
    `APR_ASSERT_NEXT(a_first_word_latency, clk, rst_n,
        start && !busy && !result_valid && !$past(start) && !$past(start, 2) && !$past(start, 3),
        ##2 result_valid, "first word late")

endmodule

bind arm32_pc_relative_relocator_top apr_checker u_apr_checker (.*);
